FILE: hw/rtl/tlbt_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tlbt_pkg
// Types and constants shared by the address translator.
// -----------------------------------------------------------------------------
package tlbt_pkg;
   localparam int TLB_ENTRIES = 16;
   localparam int FRAME_COUNT = 256;
   localparam int OFFSET_BITS = 8;
   localparam int ADDR_BITS = 16;
   localparam int PAGE_BITS = ADDR_BITS - OFFSET_BITS;
   localparam int FRAME_BITS = $clog2(FRAME_COUNT);
   localparam int COUNT_BITS = $clog2(FRAME_COUNT + 1);
   localparam int SLOT_BITS = $clog2(TLB_ENTRIES);
   localparam int STAMP_BITS = 32;
   localparam int LIMIT_BITS = 9;
   localparam int CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_LIMIT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TSCAN,
      ST_LSCAN,
      ST_VSCAN,
      ST_FIX,
      ST_DONE
   } state_type;

   // memory access request from sequencer
   typedef struct packed {
      logic                  rd_en;
      logic [FRAME_BITS-1:0] rd_addr;
      logic                  wr_en;
      logic [FRAME_BITS-1:0] wr_addr;
      logic [PAGE_BITS-1:0]  wr_page;
      logic [STAMP_BITS-1:0] wr_stamp;
      logic                  wr_owner;
   } mem_req_type;
endpackage
`default_nettype wire

FILE: hw/rtl/tlbt_if.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tlbt_req_if / tlbt_rsp_if
// Valid/ready channels for translation requests and responses.
// -----------------------------------------------------------------------------
interface tlbt_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] virt_addr;
   modport source (output valid, output virt_addr, input ready);
   modport sink (input valid, input virt_addr, output ready);
endinterface

interface tlbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] phys_addr;
   logic        tlb_hit;
   logic        page_fault;
   logic        evicted;
   logic [7:0]  evicted_page;
   modport source (output valid, output phys_addr, output tlb_hit,
                   output page_fault, output evicted, output evicted_page, input ready);
   modport sink (input valid, input phys_addr, input tlb_hit,
                 input page_fault, input evicted, input evicted_page, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/tlb_page_table_lru_translator_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tlb_page_table_lru_translator_top
// Address translator with a 16-entry FIFO TLB and LRU frame replacement.
// -----------------------------------------------------------------------------
// One transaction at a time. A TLB lookup scans the TLB one entry per cycle; a
// miss scans the frames in use in the frame table one entry per cycle through
// the read port of the frame memory, and an eviction scans them again for the
// lowest stamp.
// frame_limit lies at csr byte address 0; reads return it.
module tlb_page_table_lru_translator_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tlbt_req_if.sink                               req,
   tlbt_rsp_if.source                             rsp,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [tlbt_pkg::CSR_ADDR_BITS+1:0] csr_paddr,
   input  wire logic [31:0]                       csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);
   import tlbt_pkg::*;

   logic [LIMIT_BITS-1:0] limit_ff;
   mem_req_type           mreq;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [STAMP_BITS-1:0] rd_stamp;

   // register file
   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) limit_ff <= LIMIT_BITS'(256);
      else if (csr_psel && csr_penable && csr_pwrite &&
               csr_paddr[CSR_ADDR_BITS+1:2] == REG_FRAME_LIMIT)
         limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
   end
   assign csr_prdata = (csr_paddr[CSR_ADDR_BITS+1:2] == REG_FRAME_LIMIT)
                       ? {{(32-LIMIT_BITS){1'b0}}, limit_ff} : '0;

   tlbt_seq u_seq (.clock, .reset, .frame_limit(limit_ff), .req, .rsp, .mreq,
                   .rd_page, .rd_stamp);
   tlbt_frame_mem u_mem (.clock, .req(mreq), .rd_page, .rd_stamp);
endmodule
`default_nettype wire

FILE: hw/rtl/tlbt_frame_mem.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tlbt_frame_mem
// Frame table: owner page and last-use stamp per frame, registered read.
// -----------------------------------------------------------------------------
module tlbt_frame_mem (
   input  wire logic                          clock,
   input  wire tlbt_pkg::mem_req_type         req,
   output logic [tlbt_pkg::PAGE_BITS-1:0]     rd_page,
   output logic [tlbt_pkg::STAMP_BITS-1:0]    rd_stamp
);
   import tlbt_pkg::*;

   logic [PAGE_BITS-1:0]  owner_mem [FRAME_COUNT];
   logic [STAMP_BITS-1:0] stamp_mem [FRAME_COUNT];

   // write port
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         stamp_mem[req.wr_addr] <= req.wr_stamp;
         if (req.wr_owner) owner_mem[req.wr_addr] <= req.wr_page;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (req.rd_en) begin
         rd_page  <= owner_mem[req.rd_addr];
         rd_stamp <= stamp_mem[req.rd_addr];
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tlbt_seq.sv
`default_nettype none
// -----------------------------------------------------------------------------
// tlbt_seq
// Sequencer: TLB scan, frame table search, LRU victim search and update.
// -----------------------------------------------------------------------------
module tlbt_seq (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [tlbt_pkg::LIMIT_BITS-1:0] frame_limit,
   tlbt_req_if.sink                            req,
   tlbt_rsp_if.source                          rsp,
   output tlbt_pkg::mem_req_type               mreq,
   input  wire logic [tlbt_pkg::PAGE_BITS-1:0]  rd_page,
   input  wire logic [tlbt_pkg::STAMP_BITS-1:0] rd_stamp
);
   import tlbt_pkg::*;

   state_type state_ff, state_in;
   logic [PAGE_BITS-1:0]   tlb_page_ff [TLB_ENTRIES];
   logic [FRAME_BITS-1:0]  tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff, tlb_valid_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic [COUNT_BITS-1:0]  used_ff, used_in;
   logic [STAMP_BITS-1:0]  clock_ff, clock_in;
   logic [PAGE_BITS-1:0]   page_ff, page_in;
   logic [OFFSET_BITS-1:0] offs_ff, offs_in;
   logic [SLOT_BITS-1:0]   tidx_ff, tidx_in;
   logic [COUNT_BITS-1:0]  idx_ff, idx_in;
   logic                   pend_ff, pend_in;
   logic [FRAME_BITS-1:0]  best_ff, best_in;
   logic [STAMP_BITS-1:0]  bstamp_ff, bstamp_in;
   logic [FRAME_BITS-1:0]  frame_ff, frame_in;
   logic                   hit_ff, hit_in, fault_ff, fault_in, ev_ff, ev_in;
   logic [PAGE_BITS-1:0]   oldp_ff, oldp_in;
   logic                   ovalid_ff, ovalid_in;
   logic                   tlb_wr;
   logic [COUNT_BITS-1:0]  limit_eff;
   logic [COUNT_BITS-1:0]  span;

   // effective limit clamped to 1..FRAME_COUNT
   always_comb begin
      if (frame_limit == '0) limit_eff = COUNT_BITS'(1);
      else if ({1'b0, frame_limit} > 10'(FRAME_COUNT)) limit_eff = COUNT_BITS'(FRAME_COUNT);
      else limit_eff = COUNT_BITS'(frame_limit);
   end
   assign span = used_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tlb_valid_ff <= '0;
         slot_ff <= '0;
         used_ff <= '0;
         clock_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tlb_valid_ff <= tlb_valid_in;
         slot_ff <= slot_in;
         used_ff <= used_in;
         clock_ff <= clock_in;
         ovalid_ff <= ovalid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff <= page_in; offs_ff <= offs_in; tidx_ff <= tidx_in; idx_ff <= idx_in;
      pend_ff <= pend_in; best_ff <= best_in; bstamp_ff <= bstamp_in;
      frame_ff <= frame_in; hit_ff <= hit_in; fault_ff <= fault_in;
      ev_ff <= ev_in; oldp_ff <= oldp_in;
      if (tlb_wr) begin
         tlb_page_ff[slot_ff] <= page_ff;
         tlb_frame_ff[slot_ff] <= frame_ff;
      end
   end

   assign req.ready = (state_ff == ST_IDLE) && !ovalid_ff;
   assign rsp.valid = ovalid_ff;
   assign rsp.phys_addr = {frame_ff, offs_ff};
   assign rsp.tlb_hit = hit_ff;
   assign rsp.page_fault = fault_ff;
   assign rsp.evicted = ev_ff;
   assign rsp.evicted_page = oldp_ff;

   always_comb begin
      state_in = state_ff; tlb_valid_in = tlb_valid_ff; slot_in = slot_ff;
      used_in = used_ff; clock_in = clock_ff; page_in = page_ff; offs_in = offs_ff;
      tidx_in = tidx_ff; idx_in = idx_ff; pend_in = 1'b0; best_in = best_ff;
      bstamp_in = bstamp_ff; frame_in = frame_ff; hit_in = hit_ff; fault_in = fault_ff;
      ev_in = ev_ff; oldp_in = oldp_ff; ovalid_in = ovalid_ff; tlb_wr = 1'b0;
      mreq = '0;
      if (rsp.valid && rsp.ready) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid && req.ready) begin
               page_in = req.virt_addr[ADDR_BITS-1:OFFSET_BITS];
               offs_in = req.virt_addr[OFFSET_BITS-1:0];
               tidx_in = '0; hit_in = 1'b0; fault_in = 1'b0; ev_in = 1'b0;
               oldp_in = '0;
               state_in = ST_TSCAN;
            end
         end
         // one tlb entry per cycle, lowest index first
         ST_TSCAN: begin
            if (tlb_valid_ff[tidx_ff] && tlb_page_ff[tidx_ff] == page_ff) begin
               hit_in = 1'b1; frame_in = tlb_frame_ff[tidx_ff]; state_in = ST_FIX;
            end else if (tidx_ff == SLOT_BITS'(TLB_ENTRIES - 1)) begin
               idx_in = '0; state_in = ST_LSCAN;
            end else tidx_in = tidx_ff + 1'b1;
         end
         // frame table search, each read issued in the cycle before its compare
         ST_LSCAN: begin
            if (pend_ff && rd_page == page_ff) begin
               frame_in = FRAME_BITS'(idx_ff - 1'b1); state_in = ST_FIX;
            end else if (idx_ff < span) begin
               mreq.rd_en = 1'b1; mreq.rd_addr = FRAME_BITS'(idx_ff);
               idx_in = idx_ff + 1'b1; pend_in = 1'b1;
            end else begin
               fault_in = 1'b1;
               if (used_ff < limit_eff) begin
                  frame_in = FRAME_BITS'(used_ff); used_in = used_ff + 1'b1;
                  state_in = ST_FIX;
               end else begin
                  idx_in = '0; state_in = ST_VSCAN;
               end
            end
         end
         // lru victim: lowest stamp, earliest index on a tie
         ST_VSCAN: begin
            if (pend_ff) begin
               if (idx_ff == COUNT_BITS'(1) || rd_stamp < bstamp_ff) begin
                  best_in = FRAME_BITS'(idx_ff - 1'b1); bstamp_in = rd_stamp;
                  oldp_in = rd_page;
               end
            end
            if (idx_ff < span) begin
               mreq.rd_en = 1'b1; mreq.rd_addr = FRAME_BITS'(idx_ff);
               idx_in = idx_ff + 1'b1; pend_in = 1'b1;
            end else if (!pend_ff || idx_ff == span) begin
               if (!pend_in) begin
                  ev_in = 1'b1;
                  frame_in = (pend_ff && (idx_ff == COUNT_BITS'(1) || rd_stamp < bstamp_ff))
                             ? FRAME_BITS'(idx_ff - 1'b1) : best_ff;
                  for (int i = 0; i < TLB_ENTRIES; i++)
                     if (tlb_frame_ff[i] == frame_in) tlb_valid_in[i] = 1'b0;
                  state_in = ST_FIX;
               end
            end
         end
         // write back stamp; owner and tlb fill on a fault
         ST_FIX: begin
            clock_in = clock_ff + 1'b1;
            mreq.wr_en = 1'b1; mreq.wr_addr = frame_ff; mreq.wr_stamp = clock_in;
            mreq.wr_page = page_ff; mreq.wr_owner = fault_ff;
            if (fault_ff) begin
               tlb_wr = 1'b1; tlb_valid_in[slot_ff] = 1'b1;
               slot_in = (slot_ff == SLOT_BITS'(TLB_ENTRIES - 1)) ? '0 : slot_ff + 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            ovalid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // checks
   a_used_le: assert property (@(posedge clock) disable iff (reset)
      used_ff <= COUNT_BITS'(FRAME_COUNT)) else $error("frames in use overflow");
   a_evict_fault: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (!rsp.evicted || rsp.page_fault)) else $error("evict without fault");
   a_hit_nofault: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.tlb_hit && rsp.page_fault)) else $error("hit and fault");
   a_stamp: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIX |=> clock_ff == $past(clock_ff) + 1'b1) else $error("stamp");
endmodule
`default_nettype wire
